@@ hdl/crc16_forward_reverse_step_unit_defines.svh @@
// ----------------------------------------------------------------------------
// CRC-16 step unit assertion macros
// Shared property forms for the checker of the CRC-16 step unit.
// ----------------------------------------------------------------------------
`ifndef CRC16_FORWARD_REVERSE_STEP_UNIT_DEFINES_SVH
`define CRC16_FORWARD_REVERSE_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define CRC16_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`define CRC16_ASSERT_DELAY2(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after reset is applied.
`define CRC16_ASSERT_AFTER_RESET(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/crc16fr_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC-16 step unit package
// Item kinds, polynomial constants and the forward and reverse byte steps
// of the non-reflected CCITT polynomial 0x1021.
// ----------------------------------------------------------------------------
package crc16fr_pkg;

   typedef logic [1:0]  kind_type;
   typedef logic [15:0] crc_type;
   typedef logic [7:0]  byte_type;

   localparam kind_type KIND_FORWARD = 2'd0;
   localparam kind_type KIND_REVERSE = 2'd1;
   localparam kind_type KIND_LOAD    = 2'd2;

   localparam crc_type CRC_POLY = 16'h1021;
   localparam crc_type CRC_TOP  = 16'h8000;

   // Fold one byte in, most significant bit first.
   function automatic crc_type crc_fold_byte(input crc_type reg_value, input byte_type data);
      crc_type r;
      r = reg_value ^ {data, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (r[15]) begin
            r = {r[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[14:0], 1'b0};
         end
      end
      return r;
   endfunction

   // Exact inverse of the fold. The polynomial has bit 0 set, so bit 0 of
   // each shifted value tells whether the polynomial was applied.
   function automatic crc_type crc_unfold_byte(input crc_type reg_value, input byte_type data);
      crc_type r;
      logic    top;
      r = reg_value;
      for (int k = 0; k < 8; k++) begin
         top = r[0];
         if (top) begin
            r = r ^ CRC_POLY;
         end
         r = {top, r[15:1]};
      end
      return r ^ {data, 8'h00};
   endfunction

endpackage

@@ hdl/crc16_forward_reverse_step_unit.sv @@
// ----------------------------------------------------------------------------
// CRC-16 forward/reverse step unit
// Throughput: one beat per cycle unless the receiver stalls the result slot.
// The byte step is one XOR network between the input register and the CRC
// register, which also drives the result port.
// Reset clears the CRC register to zero and empties both stages.
// ----------------------------------------------------------------------------
module crc16_forward_reverse_step_unit
   import crc16fr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_load_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum
);

   logic     in_valid_ff;
   logic     in_valid_in;
   kind_type in_kind_ff;
   byte_type in_byte_ff;
   crc_type  in_load_ff;
   logic     out_valid_ff;
   logic     out_valid_in;
   crc_type  crc_ff;
   crc_type  crc_in;
   logic     out_free;
   logic     advance;
   logic     req_take;

   // The CRC register only changes when a beat moves into the result slot,
   // so it doubles as the result payload.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      case (in_kind_ff)
         KIND_FORWARD: crc_in = crc_fold_byte(crc_ff, in_byte_ff);
         KIND_REVERSE: crc_in = crc_unfold_byte(crc_ff, in_byte_ff);
         KIND_LOAD:    crc_in = in_load_ff;
         default:      crc_in = crc_ff;
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            crc_ff <= crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= req_kind;
         in_byte_ff <= req_data_byte;
         in_load_ff <= req_load_value;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_checksum = crc_ff;

endmodule

@@ hdl/crc16fr_checker.sv @@
// ----------------------------------------------------------------------------
// CRC-16 step unit port checker
// Watches the ports of the step unit for reset, hold and delivery behavior.
// ----------------------------------------------------------------------------
`include "crc16_forward_reverse_step_unit_defines.svh"

module crc16fr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_checksum
);

   // A stalled result beat keeps its checksum.
   `CRC16_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_checksum), "result beat dropped or changed while stalled")

   `CRC16_ASSERT_AFTER_RESET(a_reset_empty, !rsp_valid && !req_stall, "unit not empty after reset")

   // Every accepted beat has reached or is waiting behind the result slot.
   `CRC16_ASSERT_DELAY2(a_req_delivered, req_valid && !req_stall, rsp_valid, "accepted beat produced no result")

endmodule

bind crc16_forward_reverse_step_unit crc16fr_checker u_crc16fr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_checksum (rsp_checksum)
);

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CRC-16 forward/reverse step unit testbench
// Drives load, forward, reverse and unused-kind beats into the step unit and
// predicts every checksum with a bit-serial model of the CCITT register.
// The sender works in random bursts and the receiver stalls on a pattern of
// its own, with long hold-offs that back the unit up into its input.
// ----------------------------------------------------------------------------
module tb_top;
   import crc16fr_pkg::*;

   localparam kind_type    KIND_UNUSED  = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1800;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned MAX_REPORTS  = 10;

   // Tracks the CRC register and the checksums still owed by the unit.
   class checksum_tracker;
      crc_type     crc_state;
      crc_type     expected_checksums[$];
      int unsigned failures;

      function new();
         crc_state = '0;
         failures  = 0;
      endfunction

      function void note_request(kind_type kind, byte_type data, crc_type load);
         crc_type next;
         logic    fb;
         next = crc_state;
         case (kind)
            KIND_FORWARD: begin
               for (int i = 7; i >= 0; i--) begin
                  fb   = next[15] ^ data[i];
                  next = {next[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
               end
            end
            KIND_REVERSE: begin
               // Bit 0 of the shifted register shows whether the polynomial
               // went in, so each data bit can be peeled off in turn.
               for (int i = 0; i < 8; i++) begin
                  fb       = next[0];
                  next     = (next ^ (fb ? CRC_POLY : 16'h0000)) >> 1;
                  next[15] = fb ^ data[i];
               end
            end
            KIND_LOAD: next = load;
            default: next = crc_state;
         endcase
         crc_state = next;
         expected_checksums.push_back(next);
      endfunction

      function void check_result(crc_type actual);
         crc_type expected;
         if (expected_checksums.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("%0t: checksum %h arrived with none expected", $realtime, actual);
         end else begin
            expected = expected_checksums.pop_front();
            if (actual !== expected) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: checksum mismatch, expected %h, actual %h",
                           $realtime, expected, actual);
            end
         end
      endfunction

      function int unsigned pending();
         return expected_checksums.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_kind;
   logic [7:0]  req_data_byte;
   logic [15:0] req_load_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_checksum;

   checksum_tracker tracker = new();
   int unsigned     cycle_count = 0;
   int unsigned     items_sent = 0;
   int unsigned     burst_left = 0;

   crc16_forward_reverse_step_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_data_byte  (req_data_byte),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_checksum   (rsp_checksum)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_request(req_kind, req_data_byte, req_load_value);
         if (rsp_valid && !rsp_stall)
            tracker.check_result(rsp_checksum);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("crc16_forward_reverse_step_unit regression: fail");
      $finish;
   end

   // Offers one beat and holds it until it is taken; called at a rising edge.
   task automatic send_beat(kind_type kind, byte_type data, crc_type load);
      int unsigned gap;
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_data_byte  <= data;
      req_load_value <= load;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                  : $urandom_range(1, 16);
      end
   endtask

   task automatic send_random_beat(kind_type kind);
      send_beat(kind, byte_type'($urandom_range(0, 255)),
                crc_type'($urandom_range(0, 65535)));
   endtask

   // Receiver: switches between random stall patterns and twice holds off
   // for a long stretch so the unit fills and stalls its input.
   initial begin
      int unsigned taken;
      int unsigned next_hold;
      int unsigned mode;
      int unsigned mode_left;
      taken     = 0;
      next_hold = 300;
      mode      = 0;
      mode_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            taken++;
         if (taken >= next_hold) begin
            next_hold += 900;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= cycle_count[0];
            endcase
         end
      end
   end

   initial begin
      byte_type    trail[$];
      byte_type    b;
      int unsigned n;
      int unsigned target;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_kind       <= KIND_FORWARD;
      req_data_byte  <= '0;
      req_load_value <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = 30;

      // Directed beats: field extremes, every kind, ignored fields and the
      // unused kind holding the register.
      send_beat(KIND_FORWARD, 8'h00, 16'hffff);
      send_beat(KIND_LOAD,    8'haa, 16'hffff);
      send_beat(KIND_FORWARD, 8'hff, 16'h0000);
      send_beat(KIND_REVERSE, 8'hff, 16'h0000);
      send_beat(KIND_REVERSE, 8'h00, 16'hffff);
      send_beat(KIND_FORWARD, 8'h00, 16'h0000);
      send_beat(KIND_LOAD,    8'hff, 16'h0000);
      send_beat(KIND_REVERSE, 8'h00, 16'h0000);
      send_beat(KIND_REVERSE, 8'hff, 16'h0000);
      send_beat(KIND_FORWARD, 8'hff, 16'hffff);
      send_beat(KIND_UNUSED,  8'hff, 16'hffff);
      send_beat(KIND_LOAD,    8'h00, 16'h8000);
      send_beat(KIND_FORWARD, 8'h80, 16'h0000);
      send_beat(KIND_FORWARD, 8'h01, 16'hffff);
      send_beat(KIND_REVERSE, 8'h01, 16'hffff);
      send_beat(KIND_REVERSE, 8'h80, 16'h0000);
      send_beat(KIND_LOAD,    8'h55, 16'h0001);
      send_beat(KIND_REVERSE, 8'h55, 16'h5555);
      send_beat(KIND_UNUSED,  8'h00, 16'h0000);
      send_beat(KIND_LOAD,    8'h00, 16'h1021);
      send_beat(KIND_FORWARD, 8'h5a, 16'haaaa);
      send_beat(KIND_UNUSED,  8'ha5, 16'h1234);

      // Random part: mostly fold-then-unfold runs that should walk the
      // register back, some with a flipped byte, mixed with loose beats.
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 1) == 1)
               send_random_beat(KIND_LOAD);
            n = $urandom_range(1, 12);
            trail.delete();
            repeat (n) begin
               b = byte_type'($urandom_range(0, 255));
               trail.push_back(b);
               send_beat(KIND_FORWARD, b, crc_type'($urandom_range(0, 65535)));
            end
            while (trail.size() > 0) begin
               b = trail.pop_back();
               if ($urandom_range(0, 15) == 0)
                  b ^= byte_type'(1 << $urandom_range(0, 7));
               send_beat(KIND_REVERSE, b, crc_type'($urandom_range(0, 65535)));
            end
         end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_random_beat(kind_type'($urandom_range(0, 3)));
         end
      end
      req_valid <= 1'b0;
      // The last beat is noted at the edge it was taken, so let that edge
      // settle before looking at what is still owed.
      @(posedge clock);

      while (tracker.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("crc16_forward_reverse_step_unit regression: pass");
      end else begin
         $display("crc16_forward_reverse_step_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ crc16_forward_reverse_step_unit.f @@
+incdir+hdl
hdl/crc16fr_pkg.sv
hdl/crc16_forward_reverse_step_unit.sv
hdl/crc16fr_checker.sv
verif/tb_top.sv
